>>> hw/rtl/cts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cts_pkg: shared types, tables and microcode for the chord tone synthesizer
// Holds the sine and note-increment tables, the chord and letter note maps,
// the control word format and the sequencer program.
// ----------------------------------------------------------------------------
package cts_pkg;

  // Phase accumulator and sine table geometry
  localparam int PHASE_BITS  = 32;
  localparam int SINE_DEPTH  = 1024;
  localparam int SINE_AW     = $clog2(SINE_DEPTH);
  localparam int SINE_IDX_W  = SINE_AW + 2;           // quadrant plus table index
  localparam int SINE_VW     = 15;                    // table entry width
  localparam logic [SINE_VW-1:0] SINE_MAX = 15'h7FFF;
  localparam int SAMPLE_W    = 16;

  localparam int MAX_VOICES  = 3;
  localparam int VOICE_IW    = 2;                     // voice index and count width
  localparam int NOTE_W      = 7;
  localparam int NOTE_COUNT  = 128;
  localparam int NOTES_PER_OCTAVE = 12;
  localparam int REF_OCTAVE  = 5;

  // Mixer arithmetic
  localparam int SUM_W       = 18;                    // three voices of +/-32767
  localparam int MAG_W       = 17;                    // magnitude of the sum
  localparam int VOL_W       = 15;
  localparam int PROD_W      = MAG_W + VOL_W;
  localparam int AVG_SHIFT   = 15;                    // divide by 32768
  localparam int QUOT_W      = 15;
  localparam int RECIP3_W    = 16;
  localparam int RECIP3_SHIFT = 17;
  localparam logic [RECIP3_W-1:0] RECIP3 = 16'd43691; // ceil(2^17 / 3)

  // Configuration port
  localparam int CFG_DW = 16;
  localparam int CNT_W  = 16;
  typedef enum logic [1:0] {
    REG_VOLUME          = 2'd0,
    REG_NOTE_SAMPLES    = 2'd1,
    REG_SILENCE_SAMPLES = 2'd2
  } reg_idx_t;

  localparam logic [VOL_W-1:0] VOLUME_RST  = 15'd3000;
  localparam logic [CNT_W-1:0] NOTE_RST    = 16'd13230;
  localparam logic [CNT_W-1:0] SILENCE_RST = 16'd2205;

  // Symbol decode
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_9      = 8'h39;
  localparam logic [7:0] CHAR_UA     = 8'h41;
  localparam logic [7:0] CHAR_UH     = 8'h48;
  localparam logic [7:0] CHAR_LA     = 8'h61;
  localparam logic [7:0] CHAR_LH     = 8'h68;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [VOICE_IW-1:0] CHORD_VOICES = 2'd3;
  localparam logic [VOICE_IW-1:0] SINGLE_VOICE = 2'd1;

  localparam logic [NOTE_W-1:0] CHORD_ROM [10][MAX_VOICES] = '{
    '{7'd60, 7'd64, 7'd67}, '{7'd62, 7'd65, 7'd69}, '{7'd64, 7'd67, 7'd71},
    '{7'd65, 7'd69, 7'd72}, '{7'd67, 7'd71, 7'd74}, '{7'd69, 7'd72, 7'd76},
    '{7'd71, 7'd74, 7'd77}, '{7'd72, 7'd76, 7'd79}, '{7'd74, 7'd77, 7'd81},
    '{7'd76, 7'd79, 7'd83}
  };

  // Notes for letters A through H
  localparam logic [NOTE_W-1:0] LETTER_ROM [8] = '{
    7'd69, 7'd71, 7'd60, 7'd62, 7'd64, 7'd65, 7'd67, 7'd70
  };

  // Phase increments of the octave starting at middle C, for a 32-bit phase
  localparam logic [31:0] NOTE_BASE [NOTES_PER_OCTAVE] = '{
    32'd25480119, 32'd26995246, 32'd28600467, 32'd30301139,
    32'd32102938, 32'd34011878, 32'd36034330, 32'd38177043,
    32'd40447168, 32'd42852281, 32'd45400411, 32'd48100060
  };

  typedef logic [SINE_VW-1:0]    sine_tab_t [SINE_DEPTH];
  typedef logic [PHASE_BITS-1:0] inc_tab_t  [NOTE_COUNT];

  // Quarter-wave Q1.15 sine, built by a Q30 Taylor series at elaboration
  function automatic sine_tab_t build_sine();
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam int          Q30_FRAC    = 30;
    localparam logic [63:0] Q30_ONE     = 64'd1 << Q30_FRAC;
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      x  = (64'(i) * HALF_PI_Q30) / SINE_DEPTH;
      x2 = (x * x) >> Q30_FRAC;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> Q30_FRAC) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> Q30_FRAC) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> Q30_FRAC) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> Q30_FRAC) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> Q30_FRAC) / 64'd6;
      s  = (x * t) >> Q30_FRAC;
      v  = (s * 64'd32768 + (Q30_ONE >> 1)) >> Q30_FRAC;
      tab[i] = (v > 64'(SINE_MAX)) ? SINE_MAX : v[SINE_VW-1:0];
    end
    return tab;
  endfunction

  // Phase increment of every MIDI note, scaled to the phase width
  function automatic inc_tab_t build_inc();
    inc_tab_t    tab;
    logic [63:0] inc;
    int          oct;
    int          rem;
    for (int n = 0; n < NOTE_COUNT; n++) begin
      oct = n / NOTES_PER_OCTAVE;
      rem = n % NOTES_PER_OCTAVE;
      inc = 64'(NOTE_BASE[rem]);
      if (oct >= REF_OCTAVE) begin
        inc = inc << (oct - REF_OCTAVE);
      end else begin
        inc = inc >> (REF_OCTAVE - oct);
      end
      if (PHASE_BITS >= 32) begin
        inc = inc << (PHASE_BITS - 32);
      end else begin
        inc = inc >> (32 - PHASE_BITS);
      end
      tab[n] = inc[PHASE_BITS-1:0];
    end
    return tab;
  endfunction

  // Sequencer control word
  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    UOP_WAIT, // take the next transaction
    UOP_NOP,  // branch only
    UOP_RD,   // look up the sine of the current voice
    UOP_ACC,  // add it to the sum, advance the voice phase
    UOP_MUL,  // magnitude times volume
    UOP_DIV,  // divide by voice count times 32768
    UOP_CNT,  // tick counting and note/silence sequencing
    UOP_OUT,  // load the result register
    UOP_SYM   // decode a symbol and start a sound
  } uop_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_SYMBOL,
    COND_NOT_TONE,
    COND_MORE
  } cond_t;

  typedef struct packed {
    uop_t            uop;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } cw_t;

  localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
  localparam logic [PC_W-1:0] PC_CHECK = 4'd1;
  localparam logic [PC_W-1:0] PC_RD    = 4'd2;
  localparam logic [PC_W-1:0] PC_ACC   = 4'd3;
  localparam logic [PC_W-1:0] PC_MUL   = 4'd4;
  localparam logic [PC_W-1:0] PC_DIV   = 4'd5;
  localparam logic [PC_W-1:0] PC_CNT   = 4'd6;
  localparam logic [PC_W-1:0] PC_OUT   = 4'd7;
  localparam logic [PC_W-1:0] PC_SYM   = 4'd8;
  localparam logic [PC_W-1:0] PC_LAST  = PC_SYM;

  // Program ROM: a taken condition jumps to target, otherwise step to pc + 1
  function automatic cw_t ucode(input logic [PC_W-1:0] pc);
    cw_t cw;
    case (pc)
      PC_WAIT:  cw = '{UOP_WAIT, COND_SYMBOL,   PC_SYM};
      PC_CHECK: cw = '{UOP_NOP,  COND_NOT_TONE, PC_CNT};
      PC_RD:    cw = '{UOP_RD,   COND_NEVER,    PC_WAIT};
      PC_ACC:   cw = '{UOP_ACC,  COND_MORE,     PC_RD};
      PC_MUL:   cw = '{UOP_MUL,  COND_NEVER,    PC_WAIT};
      PC_DIV:   cw = '{UOP_DIV,  COND_NEVER,    PC_WAIT};
      PC_CNT:   cw = '{UOP_CNT,  COND_NEVER,    PC_WAIT};
      PC_OUT:   cw = '{UOP_OUT,  COND_ALWAYS,   PC_WAIT};
      PC_SYM:   cw = '{UOP_SYM,  COND_ALWAYS,   PC_OUT};
      default:  cw = '{UOP_NOP,  COND_ALWAYS,   PC_WAIT};
    endcase
    return cw;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cts_sine_rom.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cts_sine_rom: full-wave sine lookup
// Folds the phase quadrant onto a quarter-wave ROM with registered read data.
// ----------------------------------------------------------------------------
module cts_sine_rom
  import cts_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [SINE_IDX_W-1:0]        rd_phase,
  output      logic signed [SAMPLE_W-1:0]   sine
);

  localparam sine_tab_t SINE_TAB = build_sine();

  logic [1:0]           quad;
  logic [SINE_AW-1:0]   idx;
  logic [SINE_AW-1:0]   addr;
  logic                 full;
  logic [SINE_VW-1:0]   rom_q_r;
  logic                 full_r;
  logic                 neg_r;
  logic [SINE_VW-1:0]   mag;
  logic [SAMPLE_W-1:0]  mag_ext;

  assign quad = rd_phase[SINE_IDX_W-1 -: 2];
  assign idx  = rd_phase[SINE_AW-1:0];
  // mirror odd quadrants; the mirror of index zero is the peak itself
  assign addr = quad[0] ? (SINE_AW'(0) - idx) : idx;
  assign full = quad[0] && (idx == '0);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rom_q_r <= SINE_TAB[addr];
      full_r  <= full;
      neg_r   <= quad[1];
    end
  end

  assign mag     = full_r ? SINE_MAX : rom_q_r;
  assign mag_ext = {1'b0, mag};
  assign sine    = neg_r ? SAMPLE_W'(-mag_ext) : mag_ext;

endmodule
`default_nettype wire

>>> hw/rtl/chord_tone_synthesizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chord_tone_synthesizer: microcoded DDS tone and chord generator
// Symbols start a chord (digits) or a single note (letters A-H); ticks give
// one signed 16-bit sample each, averaged over the voices and scaled by volume.
// ----------------------------------------------------------------------------
// A symbol passes the decode step, a silent or idle tick the check and count
// steps, a tone tick the check step, a read and accumulate per voice through
// the single sine ROM port, then multiply, divide and count; each then loads
// the result register at the output step before another transaction is taken.
// The next transaction is taken while a result still waits on out_stall.
// Reset (rst_n low, synchronous) restores register defaults and goes idle.
// ----------------------------------------------------------------------------
module chord_tone_synthesizer
  import cts_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic                        in_func,
  input  wire logic [7:0]                  in_symbol,
  // result channel
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic signed [SAMPLE_W-1:0]  out_sample,
  output      logic                        out_sample_valid,
  output      logic                        out_accepted,
  output      logic                        out_busy_res,
  // configuration port
  input  wire logic                        cfg_wr_en,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [CFG_DW-1:0]           cfg_wdata
);

  localparam inc_tab_t INC_TAB = build_inc();

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  logic [PC_W-1:0]  pc_r;
  logic [PC_W-1:0]  pc_nxt;
  cw_t              cw;
  logic             cond_hit;
  logic             hold;
  logic             in_take;
  logic             out_free;

  // Configuration registers
  logic [VOL_W-1:0] volume_r;
  logic [CNT_W-1:0] note_samples_r;
  logic [CNT_W-1:0] silence_samples_r;

  // Voice and sound state
  logic [NOTE_W-1:0]     voice_note_r  [MAX_VOICES];
  logic [PHASE_BITS-1:0] voice_phase_r [MAX_VOICES];
  logic [VOICE_IW-1:0]   voice_count_r;
  logic [CNT_W-1:0]      tick_count_r;
  logic                  in_silence_r;
  logic                  playing_r;

  // Working registers of the current transaction
  logic                       func_r;
  logic [7:0]                 sym_r;
  logic                       acc_r;
  logic [VOICE_IW-1:0]        vidx_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic                       neg_r;
  logic [PROD_W-1:0]          mag_r;
  logic [QUOT_W-1:0]          quot_r;

  // Result register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_sample_valid_r;
  logic                       out_accepted_r;
  logic                       out_busy_res_r;

  // Datapath wires
  logic signed [SAMPLE_W-1:0] rom_sine;
  logic                       rom_rd;
  logic [MAG_W-1:0]           sum_mag;
  logic [MAG_W-1:0]           avg_in;
  logic [MAG_W+RECIP3_W-1:0]  recip_prod;
  logic [QUOT_W-1:0]          quot_nxt;
  logic [CNT_W-1:0]           tick_inc;
  logic [SAMPLE_W-1:0]        quot_ext;

  // Symbol decode
  logic [7:0]          sym_up;
  logic                dec_hit;
  logic [VOICE_IW-1:0] dec_count;
  logic [NOTE_W-1:0]   dec_note [MAX_VOICES];

  // --------------------------------------------------------------------------
  // Control word fetch and handshake
  // --------------------------------------------------------------------------
  assign cw       = ucode(pc_r);
  assign in_stall = (cw.uop != UOP_WAIT);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Branch condition of the current step
  always_comb begin
    case (cw.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_SYMBOL:   cond_hit = !in_func;
      COND_NOT_TONE: cond_hit = !(playing_r && !in_silence_r);
      COND_MORE:     cond_hit = ({1'b0, vidx_r} + 3'd1) < {1'b0, voice_count_r};
      default:       cond_hit = 1'b0;
    endcase
  end

  // Hold the step while waiting for a transaction or for the result register
  always_comb begin
    case (cw.uop)
      UOP_WAIT: hold = !in_take;
      UOP_OUT:  hold = !out_free;
      default:  hold = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    if (hold) begin
      pc_nxt = pc_r;
    end else if (cond_hit) begin
      pc_nxt = cw.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Sine lookup for the current voice
  // --------------------------------------------------------------------------
  assign rom_rd = (cw.uop == UOP_RD);

  cts_sine_rom u_sine_rom (
    .clk      (clk),
    .rd_en    (rom_rd),
    .rd_phase (voice_phase_r[vidx_r][PHASE_BITS-1 -: SINE_IDX_W]),
    .sine     (rom_sine)
  );

  // --------------------------------------------------------------------------
  // Mixer arithmetic
  // --------------------------------------------------------------------------
  assign sum_mag = sum_r[SUM_W-1] ? MAG_W'(-sum_r) : MAG_W'(sum_r);

  // Divide by 32768 first, then by three for a chord (reciprocal multiply,
  // exact for every value below 2^17)
  assign avg_in     = mag_r[PROD_W-1 -: MAG_W];
  assign recip_prod = (MAG_W+RECIP3_W)'(avg_in) * (MAG_W+RECIP3_W)'(RECIP3);
  assign quot_nxt   = (voice_count_r == CHORD_VOICES)
                    ? recip_prod[RECIP3_SHIFT +: QUOT_W]
                    : avg_in[QUOT_W-1:0];

  assign tick_inc = tick_count_r + 1'b1;
  assign quot_ext = SAMPLE_W'(quot_r);

  // --------------------------------------------------------------------------
  // Symbol decode: digits pick a chord, letters (either case) pick one note
  // --------------------------------------------------------------------------
  always_comb begin
    sym_up    = sym_r;
    dec_hit   = 1'b0;
    dec_count = '0;
    for (int v = 0; v < MAX_VOICES; v++) begin
      dec_note[v] = '0;
    end
    if (sym_r inside {[CHAR_LA:CHAR_LH]}) begin
      sym_up = sym_r - CASE_OFFSET;
    end
    if (sym_r inside {[CHAR_0:CHAR_9]}) begin
      dec_hit   = 1'b1;
      dec_count = CHORD_VOICES;
      for (int v = 0; v < MAX_VOICES; v++) begin
        dec_note[v] = CHORD_ROM[4'(sym_r - CHAR_0)][v];
      end
    end else if (sym_up inside {[CHAR_UA:CHAR_UH]}) begin
      dec_hit     = 1'b1;
      dec_count   = SINGLE_VOICE;
      dec_note[0] = LETTER_ROM[3'(sym_up - CHAR_UA)];
    end
  end

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volume_r          <= VOLUME_RST;
      note_samples_r    <= NOTE_RST;
      silence_samples_r <= SILENCE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_VOLUME:          volume_r          <= cfg_wdata[VOL_W-1:0];
        REG_NOTE_SAMPLES:    note_samples_r    <= cfg_wdata[CNT_W-1:0];
        REG_SILENCE_SAMPLES: silence_samples_r <= cfg_wdata[CNT_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sound state: start on a recognized symbol, advance voice phases, sequence tone and silence
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < MAX_VOICES; v++) begin
        voice_note_r[v]  <= '0;
        voice_phase_r[v] <= '0;
      end
      voice_count_r <= '0;
      tick_count_r  <= '0;
      in_silence_r  <= 1'b0;
      playing_r     <= 1'b0;
    end else begin
      case (cw.uop)
        UOP_SYM: begin
          // reject while busy, ignore unknown symbols
          if (!playing_r && dec_hit) begin
            for (int v = 0; v < MAX_VOICES; v++) begin
              voice_note_r[v]  <= dec_note[v];
              voice_phase_r[v] <= '0;
            end
            voice_count_r <= dec_count;
            tick_count_r  <= '0;
            in_silence_r  <= 1'b0;
            playing_r     <= 1'b1;
          end
        end
        UOP_ACC: begin
          voice_phase_r[vidx_r] <= voice_phase_r[vidx_r] + INC_TAB[voice_note_r[vidx_r]];
        end
        UOP_CNT: begin
          if (playing_r) begin
            if (!in_silence_r) begin
              if (tick_inc >= note_samples_r) begin
                tick_count_r <= '0;
                if (silence_samples_r == '0) begin
                  playing_r <= 1'b0;   // no silence: straight to idle
                end else begin
                  in_silence_r <= 1'b1;
                end
              end else begin
                tick_count_r <= tick_inc;
              end
            end else if (tick_inc >= silence_samples_r) begin
              tick_count_r <= '0;
              in_silence_r <= 1'b0;
              playing_r    <= 1'b0;
            end else begin
              tick_count_r <= tick_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Transaction working registers (payload, no reset)
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (cw.uop)
      UOP_WAIT: begin
        if (in_take) begin
          func_r <= in_func;
          sym_r  <= in_symbol;
          acc_r  <= 1'b0;
          vidx_r <= '0;
          sum_r  <= '0;
          quot_r <= '0;
          neg_r  <= 1'b0;
        end
      end
      UOP_SYM: acc_r <= !playing_r && dec_hit;
      UOP_ACC: begin
        sum_r  <= sum_r + SUM_W'(rom_sine);
        vidx_r <= vidx_r + 1'b1;
      end
      UOP_MUL: begin
        neg_r <= sum_r[SUM_W-1];
        mag_r <= PROD_W'(sum_mag) * PROD_W'(volume_r);
      end
      UOP_DIV: quot_r <= quot_nxt;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result register: load at the output step, hold while stalled
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cw.uop == UOP_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((cw.uop == UOP_OUT) && out_free) begin
      out_sample_r       <= neg_r ? SAMPLE_W'(-quot_ext) : quot_ext;
      out_sample_valid_r <= func_r;
      out_accepted_r     <= acc_r;
      out_busy_res_r     <= playing_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_sample_valid = out_sample_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_busy_res     = out_busy_res_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PC_LAST)
    else $error("sequencer left the program");

  a_result_from_out_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pc_r == PC_OUT))
    else $error("result loaded outside the output step");

  a_playing_has_voices: assert property (@(posedge clk) disable iff (!rst_n)
    playing_r |-> (voice_count_r == CHORD_VOICES || voice_count_r == SINGLE_VOICE))
    else $error("playing without a valid voice count");

  a_silence_only_playing: assert property (@(posedge clk) disable iff (!rst_n)
    in_silence_r |-> playing_r)
    else $error("silence phase while idle");

  a_voice_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == PC_RD) |-> (vidx_r < voice_count_r))
    else $error("sine lookup for a voice beyond the voice count");

endmodule
`default_nettype wire

>>> dv/tb_chord_tone_synthesizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chord_tone_synthesizer: self-checking bench for the chord tone synthesizer
// Sends symbol and sample-tick transactions over the valid/stall channel,
// predicts each result with an independent DDS model of the voices and
// compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_chord_tone_synthesizer;
  import cts_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int DRAIN_CYCLES = 32;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 94;

  // Transaction kinds carried on in_func
  localparam logic IN_SYMBOL = 1'b0;
  localparam logic IN_TICK   = 1'b1;

  // Register index that decodes to nothing
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam logic [7:0] LOWER_TO_UPPER = 8'h20;

  // Quarter-wave sine geometry and Q30 constants for the table build
  localparam int              QTR_DEPTH = 1024;
  localparam longint unsigned Q30_UNIT  = 64'd1 << 30;
  localparam longint unsigned HALF_PI   = 64'd1686629713;

  // Phase steps of the octave from middle C at 44.1 kHz, 32-bit phase
  localparam logic [31:0] OCTAVE_STEP [12] = '{
    32'd25480119, 32'd26995246, 32'd28600467, 32'd30301139,
    32'd32102938, 32'd34011878, 32'd36034330, 32'd38177043,
    32'd40447168, 32'd42852281, 32'd45400411, 32'd48100060
  };

  localparam logic [6:0] TRIAD_PITCHES [10][3] = '{
    '{7'd60, 7'd64, 7'd67}, '{7'd62, 7'd65, 7'd69}, '{7'd64, 7'd67, 7'd71},
    '{7'd65, 7'd69, 7'd72}, '{7'd67, 7'd71, 7'd74}, '{7'd69, 7'd72, 7'd76},
    '{7'd71, 7'd74, 7'd77}, '{7'd72, 7'd76, 7'd79}, '{7'd74, 7'd77, 7'd81},
    '{7'd76, 7'd79, 7'd83}
  };

  // Notes of the letters A through H
  localparam logic [6:0] LETTER_NOTES [8] = '{
    7'd69, 7'd71, 7'd60, 7'd62, 7'd64, 7'd65, 7'd67, 7'd70
  };

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_valid;
    logic                       accepted;
    logic                       busy;
  } tone_result_t;

  // Tone predictor plus the queue of results the DUT still owes
  class tone_scoreboard;
    logic [14:0]  quarter_sine [QTR_DEPTH];
    logic [14:0]  volume;
    logic [15:0]  note_len;
    logic [15:0]  silence_len;
    logic [6:0]   voice_pitch [3];
    logic [31:0]  voice_acc [3];
    int unsigned  voices;
    logic [15:0]  ticks;
    bit           resting;
    bit           sounding;
    tone_result_t expected_q [$];
    int           errors;

    function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned v;
      longint unsigned divs [5];
      divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
      for (int i = 0; i < QTR_DEPTH; i++) begin
        x  = (64'(i) * HALF_PI) / QTR_DEPTH;
        x2 = (x * x) >> 30;
        t  = Q30_UNIT;
        for (int k = 0; k < 5; k++) begin
          t = Q30_UNIT - ((x2 * t) >> 30) / divs[k];
        end
        s = (x * t) >> 30;
        v = (s * 64'd32768 + (Q30_UNIT >> 1)) >> 30;
        quarter_sine[i] = (v > 64'd32767) ? 15'h7FFF : v[14:0];
      end
      // Register defaults after reset
      volume      = 15'd3000;
      note_len    = 16'd13230;
      silence_len = 16'd2205;
      for (int j = 0; j < 3; j++) begin
        voice_pitch[j] = '0;
        voice_acc[j]   = '0;
      end
      voices   = 0;
      ticks    = '0;
      resting  = 1'b0;
      sounding = 1'b0;
      errors   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CFG_DW-1:0] value);
      case (idx)
        REG_VOLUME:          volume      = value[14:0];
        REG_NOTE_SAMPLES:    note_len    = value;
        REG_SILENCE_SAMPLES: silence_len = value;
        default: ;
      endcase
    endfunction

    function logic [31:0] pitch_step(logic [6:0] note);
      int unsigned     octave;
      longint unsigned step;
      octave = note / 12;
      step   = OCTAVE_STEP[note % 12];
      if (octave >= 5) begin
        step = step << (octave - 5);
      end else begin
        step = step >> (5 - octave);
      end
      return step[31:0];
    endfunction

    // Top two phase bits pick the quadrant, the next ten the table entry
    function int wave_at(logic [31:0] ph);
      logic [1:0] quad;
      logic [9:0] k;
      int         v;
      quad = ph[31:30];
      k    = ph[29:20];
      if (quad[0]) begin
        v = (k == 10'd0) ? 32767 : int'(quarter_sine[QTR_DEPTH - int'(k)]);
      end else begin
        v = int'(quarter_sine[k]);
      end
      return quad[1] ? -v : v;
    endfunction

    // Average the voices, scale by volume, truncate toward zero
    function int mix_voices();
      int              sum;
      int unsigned     n;
      longint unsigned mag;
      longint unsigned quo;
      sum = 0;
      n   = voices & 3;
      if (n > 3) n = 3;
      for (int j = 0; j < n; j++) begin
        sum += wave_at(voice_acc[j]);
        voice_acc[j] = voice_acc[j] + pitch_step(voice_pitch[j]);
      end
      if (n == 0) return 0;
      mag = 64'(sum < 0 ? -sum : sum) * 64'(volume);
      quo = mag / (64'(n) * 64'd32768);
      return (sum < 0) ? -int'(quo) : int'(quo);
    endfunction

    function bit start_sound(logic [7:0] sym);
      logic [7:0] c;
      c = sym;
      if (c >= "0" && c <= "9") begin
        for (int j = 0; j < 3; j++) begin
          voice_pitch[j] = TRIAD_PITCHES[c - "0"][j];
        end
        voices = 3;
        return 1'b1;
      end
      if (c >= "a" && c <= "h") c = c - LOWER_TO_UPPER;
      if (c >= "A" && c <= "H") begin
        voice_pitch[0] = LETTER_NOTES[c - "A"];
        voice_pitch[1] = '0;
        voice_pitch[2] = '0;
        voices = 1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Returns 1 when the transaction did something (a tick or a started sound)
    function bit note_input(logic func, logic [7:0] sym);
      tone_result_t r;
      bit           counted;
      r.sample       = '0;
      r.sample_valid = 1'b0;
      r.accepted     = 1'b0;
      counted        = 1'b0;
      if (func == IN_SYMBOL) begin
        if (!sounding && start_sound(sym)) begin
          for (int j = 0; j < 3; j++) voice_acc[j] = '0;
          ticks      = '0;
          resting    = 1'b0;
          sounding   = 1'b1;
          r.accepted = 1'b1;
          counted    = 1'b1;
        end
      end else begin
        counted        = 1'b1;
        r.sample_valid = 1'b1;
        if (sounding) begin
          ticks = ticks + 16'd1;
          if (!resting) begin
            r.sample = mix_voices();
            if (ticks >= note_len) begin
              ticks   = '0;
              resting = 1'b1;
              if (silence_len == 16'd0) begin
                resting  = 1'b0;
                sounding = 1'b0;
              end
            end
          end else if (ticks >= silence_len) begin
            ticks    = '0;
            resting  = 1'b0;
            sounding = 1'b0;
          end
        end
      end
      r.busy = sounding;
      expected_q.push_back(r);
      return counted;
    endfunction

    function void match_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] s, logic sv, logic acc,
                               logic busy);
      tone_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual sample %0d", $time, s);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      match_field("sample", e.sample, s);
      match_field("sample_valid", e.sample_valid, sv);
      match_field("accepted", e.accepted, acc);
      match_field("busy_res", e.busy, busy);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit is_playing();
      return sounding;
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic                       in_func   = IN_SYMBOL;
  logic [7:0]                 in_symbol = 8'h00;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_sample_valid;
  logic                       out_accepted;
  logic                       out_busy_res;
  logic                       cfg_wr_en = 1'b0;
  logic [1:0]                 cfg_index = 2'd0;
  logic [CFG_DW-1:0]          cfg_wdata = '0;

  int unsigned    send_idle_pct = 21;
  int unsigned    recv_idle_pct = 60;
  int             cycle_count   = 0;
  tone_scoreboard sb = new();

  chord_tone_synthesizer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_symbol        (in_symbol),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_sample_valid (out_sample_valid),
    .out_accepted     (out_accepted),
    .out_busy_res     (out_busy_res),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: check what the edge accepted, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_sample, out_sample_valid, out_accepted, out_busy_res);
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: end the run if the traffic never finishes
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Present one transaction, hold it through stalls, log it once accepted.
  // The caller must follow with another send_item or drain in the same step,
  // so that in_valid never stays high past the accepting edge.
  task automatic send_item(input logic func, input logic [7:0] sym, output bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= func;
    in_symbol <= sym;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    counted = sb.note_input(func, sym);
  endtask

  task automatic play_text(input string txt);
    bit counted;
    for (int i = 0; i < txt.len(); i++) begin
      send_item(IN_SYMBOL, txt[i], counted);
    end
  endtask

  // Ticks carry a random symbol byte, which the block must ignore
  task automatic send_ticks(input int n);
    bit counted;
    for (int i = 0; i < n; i++) begin
      send_item(IN_TICK, 8'($urandom_range(255)), counted);
    end
  endtask

  task automatic send_byte(input logic [7:0] sym);
    bit counted;
    send_item(IN_SYMBOL, sym, counted);
  endtask

  // Drop valid and hold off until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  // A recognized symbol: a digit, or a letter A-H in either case
  function automatic logic [7:0] pick_symbol();
    int unsigned r;
    r = $urandom_range(17);
    if (r < 10) return 8'("0") + 8'(r);
    return 8'("A") + 8'(r - 10) + ($urandom_range(1) ? LOWER_TO_UPPER : 8'h00);
  endfunction

  initial begin
    bit          counted;
    int          done;
    int unsigned pick;
    logic        func;
    logic [7:0]  sym;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: idle tick, ignored bytes (NUL, 0xFF, CR, LF and the decode
    // boundaries), a chord, a letter rejected while busy, a few tone ticks
    send_ticks(1);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h0D);
    send_byte(8'h0A);
    play_text("/:@I`i");
    play_text("5b");
    send_ticks(3);
    drain();

    // Shorten the note mid-sound (volume bit 15 is masked off); zero silence
    // sends the block idle on the tone's last tick
    write_reg(REG_VOLUME, 16'hFFFF);
    write_reg(REG_NOTE_SAMPLES, 16'd2);
    write_reg(REG_SILENCE_SAMPLES, 16'd0);
    send_ticks(2);
    play_text("Hh");
    send_ticks(2);
    play_text("h");
    send_ticks(1);
    drain();

    // Zero note length acts as one tick; zero volume; unused index ignored
    write_reg(REG_NOTE_SAMPLES, 16'd0);
    write_reg(REG_SILENCE_SAMPLES, 16'd1);
    write_reg(REG_VOLUME, 16'd0);
    write_reg(REG_UNUSED, 16'h7FFF);
    play_text("0");
    send_ticks(3);
    drain();

    // Longest note and silence, then cut both short between transactions
    write_reg(REG_VOLUME, 16'd32767);
    write_reg(REG_NOTE_SAMPLES, 16'hFFFF);
    write_reg(REG_SILENCE_SAMPLES, 16'hFFFF);
    play_text("9");
    send_ticks(3);
    drain();
    write_reg(REG_NOTE_SAMPLES, 16'd1);
    send_ticks(2);
    drain();
    write_reg(REG_SILENCE_SAMPLES, 16'd1);
    send_ticks(2);

    // Random phases: short notes for many starts, long ones to sweep all
    // four quadrants of the sine; rotate the idling pattern every two phases
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p / 2)
        0:       begin send_idle_pct = 21; recv_idle_pct = 60; end
        1:       begin send_idle_pct = 60; recv_idle_pct = 21; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      write_reg(REG_VOLUME, 16'($urandom_range(65535)));
      write_reg(REG_NOTE_SAMPLES,
                16'((p % 2 == 0) ? $urandom_range(8, 1) : $urandom_range(220, 120)));
      write_reg(REG_SILENCE_SAMPLES, 16'($urandom_range(4)));
      done = 0;
      while (done < PHASE_ITEMS) begin
        // Now and then let the pipeline run completely dry
        if ($urandom_range(99) < 2) drain();
        pick = $urandom_range(99);
        sym  = 8'($urandom_range(255));
        if (!sb.is_playing()) begin
          if (pick < 55) begin
            func = IN_SYMBOL;
            sym  = pick_symbol();
          end else if (pick < 70) begin
            func = IN_SYMBOL;
          end else begin
            func = IN_TICK;
          end
        end else if (pick < 8) begin
          // Symbol while busy: must be rejected
          func = IN_SYMBOL;
          if (pick < 4) sym = pick_symbol();
        end else begin
          func = IN_TICK;
        end
        send_item(func, sym, counted);
        if (counted) done++;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, sb.pending());
    end
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
